// File: design/lect_pkg.sv
// Shared types and constants of the layered entity collision table.
// Used by lect_store and layered_entity_collision_table; depends on nothing.
package lect_pkg;

	// command codes
	localparam logic [2:0] CMD_APPEND   = 3'd0;
	localparam logic [2:0] CMD_SET_POS  = 3'd1;
	localparam logic [2:0] CMD_COLLIDE  = 3'd2;
	localparam logic [2:0] CMD_FIND_NTH = 3'd3;
	localparam logic [2:0] CMD_MARK     = 3'd4;
	localparam logic [2:0] CMD_COMPACT  = 3'd5;

	localparam int CNT_W = 7;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
	} pos_t;

	typedef struct packed {
		logic [15:0] type_id;
		logic [7:0]  w;
		logic [7:0]  h;
		logic        mark;
	} info_t;

endpackage

// File: design/lect_store.sv
// Entity storage: position memory and type/size/mark memory, one registered
// read port each and one write port each. Depends on lect_pkg.
module lect_store import lect_pkg::*; #(
	parameter int AW = 8
) (
	input  logic          clk,
	input  logic [AW-1:0] rd_addr,
	output pos_t          rd_pos,
	output info_t         rd_info,
	input  logic [AW-1:0] wr_addr,
	input  logic          pos_we,
	input  pos_t          wr_pos,
	input  logic          info_we,
	input  info_t         wr_info
);

	localparam int DEPTH = 2 ** AW;

	pos_t  pos_mem  [DEPTH];
	info_t info_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (pos_we)
			pos_mem[wr_addr] <= wr_pos;
		rd_pos <= pos_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (info_we)
			info_mem[wr_addr] <= wr_info;
		rd_info <= info_mem[rd_addr];
	end

endmodule

// File: design/layered_entity_collision_table.sv
// Layered entity collision table: per-layer box table with append, move,
// overlap query, nth-of-type search, release marking and compaction.
// Depends on lect_pkg and lect_store.
//
// Usage:
//   Command beats enter on the in_ channel (in_valid / in_stall); each
//   command yields exactly one result beat on the out_ channel
//   (out_valid / out_stall) carrying ok, result_slot and layer_count.
//   The block works on one command at a time: in_stall is low only while
//   the sequencer is idle, so a new beat is taken while a finished result
//   still sits in the output register waiting for the receiver.
//   Steps, accept to result register:
//     bad layer, append, set position, unused codes: dispatch, then final
//     mark release: read the entry, write it back with the mark set
//     find nth: one memory read per slot below the count, pipelined
//     collide query: capture the query entry, then scan like find nth
//     compact: read and check each slot; a released slot takes the last entry
//   The memory read port, one entry per cycle, sets the scan rate.
//   Reset clears the layer counts and the sequencer; the entity memories are
//   not cleared, and only slots below a layer's count are ever used.
//   When the receiver stalls, the result holds in the output register and a
//   finished command waits in its final state until the register frees up.
module layered_entity_collision_table import lect_pkg::*; #(
	parameter int NUM_LAYERS    = 4,
	parameter int LAYER_ENTRIES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         cmd,
	input  logic [2:0]         layer,
	input  logic [5:0]         slot_index,
	input  logic [15:0]        type_id,
	input  logic signed [15:0] x_pos,
	input  logic signed [15:0] y_pos,
	input  logic [7:0]         box_width,
	input  logic [7:0]         box_height,
	input  logic [6:0]         occurrence,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               ok,
	output logic [5:0]         result_slot,
	output logic [6:0]         layer_count
);

	localparam int LW = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
	localparam int SW = (LAYER_ENTRIES > 1) ? $clog2(LAYER_ENTRIES) : 1;
	localparam int AW = LW + SW;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(LAYER_ENTRIES);
	localparam logic [3:0] NUM_L = 4'(NUM_LAYERS);

	// sequencer states
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DISP   = 4'd1;
	localparam logic [3:0] S_CAP    = 4'd2;
	localparam logic [3:0] S_SCAN   = 4'd3;
	localparam logic [3:0] S_MARK   = 4'd4;
	localparam logic [3:0] S_C_RD   = 4'd5;
	localparam logic [3:0] S_C_CHK  = 4'd6;
	localparam logic [3:0] S_C_MOVE = 4'd7;
	localparam logic [3:0] S_FIN    = 4'd8;

	logic [3:0] state_q;

	// captured command
	logic [2:0]       cmd_q;
	logic [LW-1:0]    layer_q;
	logic             bad_q;
	logic [CNT_W-1:0] slot_q;
	logic [15:0]      type_q;
	pos_t             pos_q;
	logic [7:0]       w_q;
	logic [7:0]       h_q;
	logic [6:0]       occ_q;

	// working state
	logic [CNT_W-1:0] counts_q [NUM_LAYERS];
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] idx_s1;
	logic             vld_s1;
	logic [CNT_W-1:0] found_q;
	pos_t             a_pos_q;
	info_t            a_info_q;
	logic             res_ok_q;
	logic [5:0]       res_slot_q;

	// output register
	logic             out_valid_q;
	logic             ok_q;
	logic [5:0]       slot_out_q;
	logic [CNT_W-1:0] count_out_q;

	// memory port
	logic [AW-1:0] rd_addr;
	pos_t          rd_pos;
	info_t         rd_info;
	logic [AW-1:0] wr_addr;
	logic          pos_we;
	pos_t          wr_pos;
	logic          info_we;
	info_t         wr_info;

	function automatic logic [AW-1:0] mk_addr(input logic [LW-1:0] l,
		input logic [CNT_W-1:0] s);
		mk_addr = {l, s[SW-1:0]};
	endfunction

	logic in_fire;
	logic out_free;
	logic slot_ok;
	logic scan_more;
	logic type_hit;
	logic overlap;
	logic hit;
	logic [CNT_W-1:0] cnt_dec;
	logic [CNT_W:0]   found_inc;
	logic signed [16:0] a_x_end, a_y_end, b_x_end, b_y_end;
	logic signed [16:0] a_x, a_y, b_x, b_y;

	assign in_stall = (state_q != S_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign slot_ok  = (slot_q < cnt_q);
	assign scan_more = (idx_q < cnt_q);
	assign cnt_dec  = cnt_q - CNT_W'(1);
	assign found_inc = {1'b0, found_q} + (CNT_W+1)'(1);

	// exact overlap test: extend to 17 bits so the sums never wrap
	assign a_x = {a_pos_q.x[15], a_pos_q.x};
	assign a_y = {a_pos_q.y[15], a_pos_q.y};
	assign b_x = {rd_pos.x[15], rd_pos.x};
	assign b_y = {rd_pos.y[15], rd_pos.y};
	assign a_x_end = a_x + $signed({9'd0, a_info_q.w});
	assign a_y_end = a_y + $signed({9'd0, a_info_q.h});
	assign b_x_end = b_x + $signed({9'd0, rd_info.w});
	assign b_y_end = b_y + $signed({9'd0, rd_info.h});
	assign overlap = (b_x < a_x_end) && (b_x_end > a_x) &&
		(b_y < a_y_end) && (b_y_end > a_y);

	assign type_hit = (rd_info.type_id == type_q);
	always_comb begin
		if (cmd_q == CMD_COLLIDE)
			hit = vld_s1 && type_hit && (idx_s1 != slot_q) && overlap;
		else
			hit = vld_s1 && type_hit && (found_inc == {1'b0, occ_q});
	end

	// memory address and write control
	always_comb begin
		rd_addr = mk_addr(layer_q, idx_q);
		wr_addr = mk_addr(layer_q, slot_q);
		pos_we  = 1'b0;
		info_we = 1'b0;
		wr_pos  = pos_q;
		wr_info = '{type_id: type_q, w: w_q, h: h_q, mark: 1'b0};
		case (state_q)
			S_DISP: begin
				rd_addr = mk_addr(layer_q, slot_q);
				if (!bad_q && cmd_q == CMD_APPEND && cnt_q < MAX_CNT) begin
					wr_addr = mk_addr(layer_q, cnt_q);
					pos_we  = 1'b1;
					info_we = 1'b1;
				end
				if (!bad_q && cmd_q == CMD_SET_POS && slot_ok)
					pos_we = 1'b1;
			end
			S_MARK: begin
				info_we = 1'b1;
				wr_info = rd_info;
				wr_info.mark = 1'b1;
			end
			S_C_RD: rd_addr = mk_addr(layer_q, idx_q);
			S_C_CHK: rd_addr = mk_addr(layer_q, cnt_dec);
			S_C_MOVE: begin
				// move the last entry into the released slot
				wr_addr = mk_addr(layer_q, idx_q);
				pos_we  = 1'b1;
				info_we = 1'b1;
				wr_pos  = rd_pos;
				wr_info = rd_info;
			end
			default: ;
		endcase
	end

	lect_store #(.AW(AW)) u_store (
		.clk     (clk),
		.rd_addr (rd_addr),
		.rd_pos  (rd_pos),
		.rd_info (rd_info),
		.wr_addr (wr_addr),
		.pos_we  (pos_we),
		.wr_pos  (wr_pos),
		.info_we (info_we),
		.wr_info (wr_info)
	);

	// capture the command beat
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q   <= cmd;
			layer_q <= layer[LW-1:0];
			slot_q  <= {1'b0, slot_index};
			type_q  <= type_id;
			pos_q   <= '{x: x_pos, y: y_pos};
			w_q     <= box_width;
			h_q     <= box_height;
			occ_q   <= occurrence;
		end
		if (state_q == S_CAP) begin
			a_pos_q  <= rd_pos;
			a_info_q <= rd_info;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bad_q       <= 1'b0;
			cnt_q       <= '0;
			idx_q       <= '0;
			idx_s1      <= '0;
			vld_s1      <= 1'b0;
			found_q     <= '0;
			res_ok_q    <= 1'b0;
			res_slot_q  <= '0;
			out_valid_q <= 1'b0;
			ok_q        <= 1'b0;
			slot_out_q  <= '0;
			count_out_q <= '0;
			for (int l = 0; l < NUM_LAYERS; l++)
				counts_q[l] <= '0;
		end else begin
			// load a finished result, or drop the one the receiver took
			if (state_q == S_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						bad_q      <= ({1'b0, layer} >= NUM_L);
						cnt_q      <= ({1'b0, layer} >= NUM_L) ? '0 :
							counts_q[layer[LW-1:0]];
						res_ok_q   <= 1'b0;
						res_slot_q <= '0;
						idx_q      <= '0;
						found_q    <= '0;
						vld_s1     <= 1'b0;
						state_q    <= S_DISP;
					end
				end
				S_DISP: begin
					state_q <= S_FIN;
					if (!bad_q) begin
						case (cmd_q)
							CMD_APPEND: begin
								if (cnt_q < MAX_CNT) begin
									res_ok_q   <= 1'b1;
									res_slot_q <= cnt_q[5:0];
									cnt_q      <= cnt_q + CNT_W'(1);
								end
							end
							CMD_COLLIDE: if (slot_ok) state_q <= S_CAP;
							CMD_FIND_NTH: if (occ_q != '0) state_q <= S_SCAN;
							CMD_MARK: if (slot_ok) state_q <= S_MARK;
							CMD_COMPACT: state_q <= S_C_RD;
							default: ;
						endcase
					end
				end
				S_CAP: state_q <= S_SCAN;
				S_SCAN: begin
					// issue one read per cycle, judge the entry in the next cycle
					vld_s1 <= scan_more && !hit;
					idx_s1 <= idx_q;
					if (scan_more)
						idx_q <= idx_q + CNT_W'(1);
					if (vld_s1 && type_hit)
						found_q <= found_inc[CNT_W-1:0];
					if (hit) begin
						res_ok_q   <= 1'b1;
						res_slot_q <= idx_s1[5:0];
						state_q    <= S_FIN;
					end else if (!scan_more && !vld_s1) begin
						state_q <= S_FIN;
					end
				end
				S_MARK: state_q <= S_FIN;
				S_C_RD: state_q <= scan_more ? S_C_CHK : S_FIN;
				S_C_CHK: begin
					if (rd_info.mark) begin
						cnt_q   <= cnt_dec;
						state_q <= (idx_q < cnt_dec) ? S_C_MOVE : S_C_RD;
					end else begin
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= S_C_RD;
					end
				end
				S_C_MOVE: state_q <= S_C_RD; // recheck the moved entry
				S_FIN: begin
					if (out_free) begin
						ok_q        <= res_ok_q;
						slot_out_q  <= res_slot_q;
						count_out_q <= cnt_q;
						if (!bad_q)
							counts_q[layer_q] <= cnt_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign ok          = ok_q;
	assign result_slot = slot_out_q;
	assign layer_count = count_out_q;

`ifndef SYNTH
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_CNT)
		else $error("working count exceeds layer capacity");
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FIN))
		else $error("result raised outside final state");
	a_fail_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !ok_q |-> slot_out_q == '0)
		else $error("failed result carries a slot");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == S_DISP)
		else $error("accepted beat did not start dispatch");
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !pos_we && !info_we)
		else $error("memory write while idle");
`endif

endmodule
